// ===== rtl/sds_pkg.sv =====
package sds_pkg;

    // list geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // command codes
    localparam logic [2:0] CMD_LOAD_PAIR  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_SORT       = 3'd5;
    localparam logic [2:0] CMD_MATCH      = 3'd6;
    localparam logic [2:0] CMD_COUNT      = 3'd7;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [DATA_W-1:0] operand_value;
        logic signed [DATA_W-1:0] second_value;
    } sds_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [CNT_W-1:0]         element_count;
        logic [1:0]               status;
        logic                     last_result;
    } sds_out_t;

    // ring position of the element at a given offset from the front
    function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(CAPACITY))
        begin
            sum = sum - (CNT_W+1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/sds_ram.sv =====
module sds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_deque_store.sv =====
// bounded double-ended queue of signed 32-bit values, held as a ring in one
// synchronous ram with a front index and an element count.
// request channel: a transaction is taken at a rising edge with start high and
// busy low. result channel: result_valid marks each result for exactly one
// cycle; the receiver cannot hold results off, so it must take every one.
// push, pop and count give their single result in the cycle after acceptance
// and leave busy low, so such transactions may follow every cycle.
// load pair writes two entries through the single write port: the first on
// acceptance, the second in S_LOAD2, which holds busy high and gives the result.
// match count streams the n held entries through the read port.
// sort is an in-place selection sort through the one read port and one write
// port of the ram: each pass streams offsets i+1 .. n-1 past the running
// minimum, then the n sorted elements come out on consecutive cycles; an
// empty list gives a single zero result at once.
// reset empties the list (front index and count cleared); the ram contents
// are not cleared and only live entries are ever read.
module sorted_deque_store
    import sds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  sds_in_t  request,
    output sds_out_t result,
    output logic     result_valid
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_LOAD2    = 3'd1;
    localparam logic [2:0] S_SORT_I   = 3'd2;
    localparam logic [2:0] S_SORT_CUR = 3'd3;
    localparam logic [2:0] S_SORT_J   = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;
    localparam logic [2:0] S_MATCH    = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  jd_reg, jd_next;
    logic              rv_reg, rv_next;
    logic [CNT_W-1:0]  match_reg, match_next;
    logic              result_valid_reg, result_valid_next;
    logic [DATA_W-1:0] operand_reg, operand_next;
    logic [DATA_W-1:0] second_reg, second_next;
    logic [DATA_W-1:0] cur_reg, cur_next;
    sds_out_t          result_reg, result_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    sds_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // command sequencer
    always_comb
    begin
        logic [CNT_W-1:0] m;
        logic             is_last;
        m                 = match_reg;
        is_last           = 1'b0;
        state_next        = state_reg;
        front_next        = front_reg;
        count_next        = count_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        jd_next           = jd_reg;
        rv_next           = rv_reg;
        match_next        = match_reg;
        operand_next      = operand_reg;
        second_next       = second_reg;
        cur_next          = cur_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_en             = 1'b0;
        rd_addr           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    operand_next              = request.operand_value;
                    second_next               = request.second_value;
                    result_next.result_value  = '0;
                    result_next.element_count = count_reg;
                    result_next.status        = STATUS_OK;
                    result_next.last_result   = 1'b1;
                    case (request.command)
                        CMD_LOAD_PAIR:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = request.operand_value;
                            front_next = '0;
                            state_next = S_LOAD2;
                        end
                        CMD_PUSH_FRONT:
                        begin
                            result_valid_next = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? IDX_W'(CAPACITY - 1)
                                                               : front_reg - 1'b1;
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                wr_data    = request.operand_value;
                                count_next = count_reg + 1'b1;
                                result_next.element_count = count_next;
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            result_valid_next = 1'b1;
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                result_next.status = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_pos(front_reg, count_reg);
                                wr_data    = request.operand_value;
                                count_next = count_reg + 1'b1;
                                result_next.element_count = count_next;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            result_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                result_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                front_next = ring_pos(front_reg, CNT_W'(1));
                                count_next = count_reg - 1'b1;
                                result_next.element_count = count_next;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            result_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                result_next.status = STATUS_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                result_next.element_count = count_next;
                            end
                        end
                        CMD_SORT:
                        begin
                            if (count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                            end
                            else if (count_reg == CNT_W'(1))
                            begin
                                j_next     = '0;
                                rv_next    = 1'b0;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                i_next     = '0;
                                state_next = S_SORT_I;
                            end
                        end
                        CMD_MATCH:
                        begin
                            if (count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                            end
                            else
                            begin
                                j_next     = '0;
                                rv_next    = 1'b0;
                                match_next = '0;
                                state_next = S_MATCH;
                            end
                        end
                        default:
                        begin
                            result_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            // second entry of a fresh pair
            S_LOAD2:
            begin
                wr_en                     = 1'b1;
                wr_addr                   = IDX_W'(1 % CAPACITY);
                wr_data                   = second_reg;
                count_next                = CNT_W'(2);
                result_valid_next         = 1'b1;
                result_next.result_value  = '0;
                result_next.element_count = CNT_W'(2);
                result_next.status        = STATUS_OK;
                result_next.last_result   = 1'b1;
                state_next                = S_IDLE;
            end

            // fetch the element at offset i, the running minimum of this pass
            S_SORT_I:
            begin
                rd_en      = 1'b1;
                rd_addr    = ring_pos(front_reg, i_reg);
                state_next = S_SORT_CUR;
            end

            S_SORT_CUR:
            begin
                cur_next   = rd_data;
                j_next     = i_reg + 1'b1;
                rv_next    = 1'b0;
                state_next = S_SORT_J;
            end

            // stream offsets i+1 .. n-1, swapping smaller ones into the minimum
            S_SORT_J:
            begin
                if (rv_reg && ($signed(cur_reg) > $signed(rd_data)))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ring_pos(front_reg, jd_reg);
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
                if (j_reg < count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ring_pos(front_reg, j_reg);
                    rv_next = 1'b1;
                    jd_next = j_reg;
                    j_next  = j_reg + 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                end
                // pass complete: write the minimum back at offset i
                if (!rv_reg && (j_reg >= count_reg))
                begin
                    wr_en   = 1'b1;
                    wr_addr = ring_pos(front_reg, i_reg);
                    wr_data = cur_reg;
                    i_next  = i_reg + 1'b1;
                    if ((i_reg + CNT_W'(2)) < count_reg)
                    begin
                        state_next = S_SORT_I;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            end

            // stream the sorted list out, one element a cycle
            S_EMIT:
            begin
                if (rv_reg)
                begin
                    is_last                   = ((jd_reg + 1'b1) == count_reg);
                    result_valid_next         = 1'b1;
                    result_next.result_value  = rd_data;
                    result_next.element_count = count_reg;
                    result_next.status        = STATUS_OK;
                    result_next.last_result   = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (j_reg < count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ring_pos(front_reg, j_reg);
                    rv_next = 1'b1;
                    jd_next = j_reg;
                    j_next  = j_reg + 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                end
            end

            // count entries equal to the operand
            S_MATCH:
            begin
                if (rv_reg)
                begin
                    is_last = ((jd_reg + 1'b1) == count_reg);
                    if (rd_data == operand_reg)
                    begin
                        m = match_reg + 1'b1;
                    end
                    match_next = m;
                    if (is_last)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.result_value  = DATA_W'(m);
                        result_next.element_count = count_reg;
                        result_next.status        = STATUS_OK;
                        result_next.last_result   = 1'b1;
                        state_next                = S_IDLE;
                    end
                end
                if (j_reg < count_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ring_pos(front_reg, j_reg);
                    rv_next = 1'b1;
                    jd_next = j_reg;
                    j_next  = j_reg + 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            front_reg        <= '0;
            count_reg        <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            jd_reg           <= '0;
            rv_reg           <= 1'b0;
            match_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            count_reg        <= count_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            jd_reg           <= jd_next;
            rv_reg           <= rv_next;
            match_reg        <= match_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        operand_reg <= operand_next;
        second_reg  <= second_next;
        cur_reg     <= cur_next;
        result_reg  <= result_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/sds_checker.sv =====
module sds_checker
    import sds_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input sds_in_t  request,
    input sds_out_t result,
    input logic     result_valid
);

    // a flagged transaction gives a single result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != STATUS_OK)) |-> result.last_result)
    else $error("flagged result not marked last");

    // the list never exceeds its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.element_count <= CNT_W'(CAPACITY)))
    else $error("element count beyond capacity");

    // end operations and count answer on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((request.command == CMD_PUSH_FRONT) ||
                            (request.command == CMD_PUSH_BACK) ||
                            (request.command == CMD_POP_FRONT) ||
                            (request.command == CMD_POP_BACK) ||
                            (request.command == CMD_COUNT)))
        |=> (result_valid && result.last_result))
    else $error("single-cycle transaction gave no result");

    // sorted elements stream on consecutive cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |=> result_valid)
    else $error("gap in sorted element stream");

    // sorted elements come out in ascending order
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result)
        |=> ($signed(result.result_value) >= $signed($past(result.result_value))))
    else $error("sorted elements out of order");

endmodule

bind sorted_deque_store sds_checker u_sds_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top
    import sds_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // edge values of a signed 32-bit element
    localparam int VAL_MIN = 32'h8000_0000;
    localparam int VAL_MAX = 32'h7fff_ffff;

    // a full sort and a long sender gap make the longest stretch with no accepted
    // transaction, so this limit leaves a wide margin
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PER_PHASE = 170;

    // shadow of the deque and the queue of results still owed by the block
    class deque_tracker;
        int       ring_store[CAPACITY];
        int       front_pos;
        int       live_count;
        sds_out_t awaited[$];
        int       mismatches;

        function new();
            front_pos  = 0;
            live_count = 0;
            mismatches = 0;
            foreach (ring_store[k])
            begin
                ring_store[k] = 0;
            end
        endfunction

        function int pending();
            pending = awaited.size();
        endfunction

        function void add_result(int value, logic [1:0] code, bit is_last);
            sds_out_t r;
            r.result_value  = value;
            r.element_count = CNT_W'(live_count);
            r.status        = code;
            r.last_result   = is_last;
            awaited.push_back(r);
        endfunction

        // work out what an accepted command does to the list and what it returns
        function void note_command(sds_in_t item);
            int         sorted_vals[CAPACITY];
            int         match_total;
            int         held_val;
            int         k;
            int         j;
            logic [1:0] code;
            code        = STATUS_OK;
            match_total = 0;
            if (item.command == CMD_SORT)
            begin
                // empty list still answers once, with a zero
                if (live_count == 0)
                begin
                    add_result(0, STATUS_OK, 1'b1);
                end
                else
                begin
                    for (k = 0; k < live_count; k++)
                    begin
                        sorted_vals[k] = ring_store[(front_pos + k) % CAPACITY];
                    end
                    // insertion sort, ascending as signed values
                    for (k = 1; k < live_count; k++)
                    begin
                        held_val = sorted_vals[k];
                        j = k - 1;
                        while (j >= 0 && sorted_vals[j] > held_val)
                        begin
                            sorted_vals[j + 1] = sorted_vals[j];
                            j--;
                        end
                        sorted_vals[j + 1] = held_val;
                    end
                    // sorted values go back in place, front first
                    for (k = 0; k < live_count; k++)
                    begin
                        ring_store[(front_pos + k) % CAPACITY] = sorted_vals[k];
                        add_result(sorted_vals[k], STATUS_OK, k == live_count - 1);
                    end
                end
            end
            else
            begin
                case (item.command)
                    CMD_LOAD_PAIR:
                    begin
                        ring_store[0] = item.operand_value;
                        ring_store[1] = item.second_value;
                        front_pos     = 0;
                        live_count    = 2;
                    end
                    CMD_PUSH_FRONT:
                    begin
                        if (live_count >= CAPACITY)
                        begin
                            code = STATUS_FULL;
                        end
                        else
                        begin
                            front_pos = (front_pos + CAPACITY - 1) % CAPACITY;
                            ring_store[front_pos] = item.operand_value;
                            live_count++;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (live_count >= CAPACITY)
                        begin
                            code = STATUS_FULL;
                        end
                        else
                        begin
                            ring_store[(front_pos + live_count) % CAPACITY] =
                                item.operand_value;
                            live_count++;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (live_count == 0)
                        begin
                            code = STATUS_EMPTY;
                        end
                        else
                        begin
                            front_pos = (front_pos + 1) % CAPACITY;
                            live_count--;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (live_count == 0)
                        begin
                            code = STATUS_EMPTY;
                        end
                        else
                        begin
                            live_count--;
                        end
                    end
                    CMD_MATCH:
                    begin
                        for (k = 0; k < live_count; k++)
                        begin
                            if (ring_store[(front_pos + k) % CAPACITY] == item.operand_value)
                            begin
                                match_total++;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                add_result(match_total, code, 1'b1);
            end
        endfunction

        // compare one result strobe with the oldest owed result
        function void check_result(sds_out_t got);
            sds_out_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: value %0d count %0d status %0d last %0b",
                             got.result_value, got.element_count, got.status,
                             got.last_result);
                end
            end
            else
            begin
                want = awaited.pop_front();
                if (got.result_value !== want.result_value ||
                    got.element_count !== want.element_count ||
                    got.status !== want.status ||
                    got.last_result !== want.last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected value %0d count %0d status %0d last %0b",
                                 want.result_value, want.element_count, want.status,
                                 want.last_result);
                        $display("          actual   value %0d count %0d status %0d last %0b",
                                 got.result_value, got.element_count, got.status,
                                 got.last_result);
                    end
                end
            end
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         start;
    logic         busy;
    sds_in_t      request;
    sds_out_t     result;
    logic         result_valid;

    deque_tracker tracker;
    int           idle_pct = 0;
    int           quiet_cycles = 0;

    sorted_deque_store dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result       (result),
        .result_valid (result_valid)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // note each accepted transaction, then check any result on the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                tracker.note_command(request);
            end
            if (result_valid)
            begin
                tracker.check_result(result);
            end
        end
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // present one transaction after a random gap and hold it until taken
    task automatic send_command(input logic [2:0] cmd, input int first, input int second);
        sds_in_t item;
        item.command       = cmd;
        item.operand_value = first;
        item.second_value  = second;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // mostly wide random values, some edge values and a narrow band for matches
    function automatic int pick_value();
        case ($urandom_range(0, 3))
            0, 1: pick_value = $urandom;
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       pick_value = VAL_MIN;
                    1:       pick_value = VAL_MAX;
                    2:       pick_value = 0;
                    default: pick_value = -1;
                endcase
            end
            default: pick_value = int'($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    // edge cases: empty list, extreme values, ring wrap, full list
    task automatic run_directed();
        int k;
        send_command(CMD_POP_FRONT, 0, 0);
        send_command(CMD_POP_BACK, 0, 0);
        send_command(CMD_SORT, 0, 0);
        send_command(CMD_MATCH, 0, 0);
        send_command(CMD_COUNT, 0, 0);
        send_command(CMD_LOAD_PAIR, VAL_MAX, VAL_MIN);
        send_command(CMD_SORT, -1, -1);
        send_command(CMD_MATCH, VAL_MAX, 0);
        // front pushes from index zero wrap round the ring
        for (k = 0; k < CAPACITY - 2; k++)
        begin
            send_command(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                         (k % 3 == 0) ? VAL_MIN : (k % 3 == 1) ? VAL_MAX : k - 7,
                         k[1] ? -1 : 0);
        end
        send_command(CMD_PUSH_FRONT, 5, -1);
        send_command(CMD_PUSH_BACK, 5, 0);
        send_command(CMD_SORT, 0, 0);
        send_command(CMD_POP_FRONT, 0, 0);
        send_command(CMD_POP_BACK, 0, 0);
        send_command(CMD_COUNT, 0, 0);
    endtask

    // random traffic that drifts between filling and draining the list
    task automatic run_random(input int item_total);
        int         n;
        int         pick;
        bit         grow;
        logic [2:0] cmd;
        grow = 1'b1;
        for (n = 0; n < item_total; n++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                grow = !grow;
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                cmd = CMD_LOAD_PAIR;
            end
            else if (pick < (grow ? 53 : 15))
            begin
                cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
            end
            else if (pick < 65)
            begin
                cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
            end
            else if (pick < 75)
            begin
                cmd = CMD_SORT;
            end
            else if (pick < 90)
            begin
                cmd = CMD_MATCH;
            end
            else
            begin
                cmd = CMD_COUNT;
            end
            send_command(cmd, pick_value(), pick_value());
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 15;
        run_directed();
        run_random(RANDOM_PER_PHASE);
        idle_pct = 70;
        run_random(RANDOM_PER_PHASE);
        idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        start <= 1'b0;

        // let the monitor note the last transaction before looking at the queue
        @(posedge clk);

        // drain outstanding results, then allow a short settling time
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
